// ===== hw/rtl/swau_pkg.sv =====
// ============================================================================
// Sliding-window airtime utilisation: shared package
// Field widths, scaling constants and the sequencer state type.
// ============================================================================
package swau_pkg;

    // Input fields
    localparam int TS_W      = 63;
    localparam int AIR_W     = 16;
    localparam int S_TDATA_W = ((TS_W + AIR_W + 7) / 8) * 8;

    // Result fields
    localparam int UTIL_W = 14;

    localparam int DEF_RING_DEPTH = 1024;

    // One-second window, held at the width of the timestamp compare
    localparam int                CMP_W     = TS_W + 1;
    localparam logic [CMP_W-1:0]  WINDOW_US = CMP_W'(1000000);

    // Utilisation is floor(sum / 100), capped at 10000. Any sum of at least
    // 1000000 gives the cap; below that the quotient comes from a reciprocal
    // multiply, exact for every 20-bit operand under the cap.
    localparam logic [UTIL_W-1:0] UTIL_CAP     = UTIL_W'(10000);
    localparam int                UTIL_CAP_SUM = 1000000;
    localparam int                SCALE_IN_W   = 20;
    localparam int                RECIP_W      = 21;
    localparam int                RECIP_SHIFT  = 27;
    localparam logic [RECIP_W-1:0] RECIP_100   = RECIP_W'(1342178);
    localparam int                PROD_W       = SCALE_IN_W + RECIP_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CHECK,
        ST_APPEND,
        ST_SCALE,
        ST_RESULT
    } swau_state_t;

endpackage

// ===== hw/rtl/swau_ram.sv =====
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module swau_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/swau_scale.sv =====
// ============================================================================
// Utilisation scaler
// Turns the airtime sum into hundredths of a percent with a capped
// reciprocal multiply; the result is ready in the cycle after start.
// ============================================================================
module swau_scale
    import swau_pkg::*;
#(
    parameter int SUM_W = AIR_W + 11
) (
    input  logic              aclk,
    input  logic              start,
    input  logic [SUM_W-1:0]  sum,
    output logic [UTIL_W-1:0] util
);

    localparam int EXT_W = (SUM_W > SCALE_IN_W) ? SUM_W : SCALE_IN_W;

    logic [EXT_W-1:0]  sum_ext;
    logic              cap_next;
    logic [PROD_W-1:0] prod_next;
    logic              cap_reg;
    logic [PROD_W-1:0] prod_reg;

    always_comb begin
        sum_ext   = EXT_W'(sum);
        cap_next  = (sum_ext >= EXT_W'(UTIL_CAP_SUM));
        prod_next = PROD_W'(sum_ext[SCALE_IN_W-1:0]) * PROD_W'(RECIP_100);
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cap_reg  <= cap_next;
            prod_reg <= prod_next;
        end
    end

    assign util = cap_reg ? UTIL_CAP : prod_reg[RECIP_SHIFT +: UTIL_W];

endmodule

// ===== hw/rtl/sliding_window_airtime_util_unit.sv =====
// ============================================================================
// Sliding-window airtime utilisation unit
// One-second sliding sum of packet airtime, reported as utilisation.
// ============================================================================
// Each input transaction is one received packet (timestamp and airtime in
// microseconds); each produces exactly one output transaction carrying the
// utilisation in hundredths of a percent (window airtime sum / 100, capped at
// 10000), the number of packets now in the window, and a drop flag on tuser
// that is set when the ring was full and the packet was not stored. Entries
// are held in a RAM ring of RING_DEPTH slots. Timestamps are expected to be
// non-decreasing; an older timestamp simply expires nothing. A packet steps
// through fetch, check, append, scale and result before the next input is
// taken, plus another fetch and check for each stored entry that falls out of
// the window, because expired entries are read back one at a time through the
// single registered RAM read port and retired by the one shared sum adder.
// The result sits in an output register, so a new packet can be accepted
// while the previous result waits; the unit stalls only if a second result is
// ready before the first is taken. No clearing pass is needed after reset.
// ============================================================================
module sliding_window_airtime_util_unit
    import swau_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH,
    localparam int CNT_W     = $clog2(RING_DEPTH + 1),
    localparam int M_TDATA_W = ((UTIL_W + CNT_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input packet
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // From bit 0: timestamp_us (63), pkt_airtime (16), zero padding
    input  logic [S_TDATA_W-1:0] s_tdata,
    // Result
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // From bit 0: util_centipercent (14), packets_in_window (CNT_W), zero padding
    output logic [M_TDATA_W-1:0] m_tdata,
    // Bit 0: dropped
    output logic [0:0]           m_tuser
);

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SUM_W = AIR_W + CNT_W;
    localparam int ENT_W = TS_W + AIR_W;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);

    // Sequencer and ring state
    swau_state_t          state_reg, state_next;
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;

    // Packet being processed (payload, no reset)
    logic [TS_W-1:0]      now_reg, now_next;
    logic [AIR_W-1:0]     air_reg, air_next;
    logic                 dropped_reg, dropped_next;

    // Output register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;

    // RAM ports
    logic                 ram_we;
    logic [ENT_W-1:0]     ram_wdata;
    logic [ENT_W-1:0]     ram_rdata;
    logic [TS_W-1:0]      rd_ts;
    logic [AIR_W-1:0]     rd_air;

    // Shared sum adder and window compare
    logic                 alu_sub;
    logic [SUM_W-1:0]     alu_b;
    logic [SUM_W-1:0]     alu_res;
    logic                 expired;

    logic                 scale_start;
    logic [UTIL_W-1:0]    util;

    swau_ram #(
        .WIDTH (ENT_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wr_ptr_reg),
        .wr_data (ram_wdata),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rdata)
    );

    swau_scale #(
        .SUM_W (SUM_W)
    ) u_scale (
        .aclk  (aclk),
        .start (scale_start),
        .sum   (sum_reg),
        .util  (util)
    );

    assign ram_wdata = {air_reg, now_reg};
    assign rd_ts     = ram_rdata[TS_W-1:0];
    assign rd_air    = ram_rdata[TS_W +: AIR_W];

    // An entry expires when its timestamp plus the window is strictly earlier
    // than the new packet's timestamp. The compare is one bit wider than the
    // timestamp so the addition cannot wrap.
    assign expired = (({1'b0, rd_ts} + WINDOW_US) < {1'b0, now_reg});

    // The single adder subtracts a retired entry while checking the window
    // and adds the new packet while appending.
    assign alu_sub = (state_reg == ST_CHECK);
    assign alu_b   = alu_sub ? SUM_W'(rd_air) : SUM_W'(air_reg);
    assign alu_res = alu_sub ? (sum_reg - alu_b) : (sum_reg + alu_b);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        state_next    = state_reg;
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        now_next      = now_reg;
        air_next      = air_reg;
        dropped_next  = dropped_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        ram_we        = 1'b0;
        scale_start   = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    now_next   = s_tdata[TS_W-1:0];
                    air_next   = s_tdata[TS_W +: AIR_W];
                    state_next = ST_FETCH;
                end
            end
            // The oldest entry is being read; its data arrives next cycle.
            ST_FETCH: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if ((count_reg != '0) && expired) begin
                    sum_next    = alu_res;
                    rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
                    count_next  = count_reg - 1'b1;
                    state_next  = ST_FETCH;
                end else begin
                    state_next  = ST_APPEND;
                end
            end
            ST_APPEND: begin
                if (count_reg < CNT_FULL) begin
                    ram_we       = 1'b1;
                    sum_next     = alu_res;
                    wr_ptr_next  = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
                    count_next   = count_reg + 1'b1;
                    dropped_next = 1'b0;
                end else begin
                    dropped_next = 1'b1;
                end
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                scale_start = 1'b1;
                state_next  = ST_RESULT;
            end
            // Wait here only if the previous result has not yet been taken.
            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({count_reg, util});
                    m_tuser_next  = dropped_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
            sum_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg     <= now_next;
        air_reg     <= air_next;
        dropped_reg <= dropped_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // The ring never holds more entries than it has slots.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("ring occupancy exceeds its depth");

    // A dropped packet is only ever reported against a full window.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[UTIL_W +: CNT_W] == CNT_FULL))
        else $error("drop reported while the ring was not full");

    // Accepting a packet takes the sequencer out of idle, so s_tready drops.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second packet accepted in back-to-back cycles");

    // Retiring an entry lowers the sum by exactly that entry's airtime.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK && count_reg != '0 && expired)
        |=> (sum_reg == $past(sum_reg) - SUM_W'($past(rd_air))))
        else $error("window sum not reduced by the retired airtime");

endmodule
